FILE: sv/psr_pkg.sv
package psr_pkg;

	// the input fields are 16 bits wide, a wider value width masks nothing
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned SUM_W = 28;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned STATUS_W = 2;

	// trial division always begins here
	localparam int unsigned FIRST_DIVISOR = 2;

	localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_COMPARE,
		ST_DIVIDE,
		ST_NEXT,
		ST_DONE
	} psr_state_t;

	typedef struct packed {
		logic start;
	} rem_ctl_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

FILE: sv/psr_if.sv
interface psr_in_if
	import psr_pkg::*;
;
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] range_start;
	logic [FIELD_W-1:0] range_end;

	modport source (output valid, output range_start, output range_end, input ready);
	modport sink (input valid, input range_start, input range_end, output ready);
endinterface

interface psr_out_if
	import psr_pkg::*;
;
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [SUM_W-1:0] prime_sum;
	logic [COUNT_W-1:0] prime_count;

	modport source (output valid, output status, output prime_sum, output prime_count,
		input ready);
	modport sink (input valid, input status, input prime_sum, input prime_count,
		output ready);
endinterface

FILE: sv/prime_sum_in_open_range_core.sv
// prime sum over an open range
//
// req carries one word: range_start and range_end, both exclusive bounds.
// rsp returns one word per request: status, prime_sum and prime_count.
// status is found, none or invalid (start of zero, or start not below end).
// the request side is ready only while the sequencer is idle; one request
// is worked on at a time.
// each candidate n between the bounds is tried against divisors d = 2, 3, ...
// while d*d <= n. one division is a square, a compare and a run of the
// bit-serial remainder unit over EW dividend bits, EW being the value width
// (16 by default); a candidate then advances in ST_NEXT, and a prime first
// takes its last square and compare. the remainder unit sets the rate at
// which a request is worked through; a range that is invalid or holds no
// value between the bounds skips the search.
// the result sits in an output register; a new request is taken while it
// waits for rsp.ready, but the next result is held back until it is taken.
// reset clears the sequencer, the output valid flag and the remainder unit's busy and done flags, nothing else.
module prime_sum_in_open_range_core
	import psr_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	psr_in_if.sink req,
	psr_out_if.source rsp
);

	localparam int unsigned EW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
	localparam int unsigned DW = (EW + 1) / 2 + 1;
	localparam int unsigned SW = 2 * DW;

	psr_state_t state_q;
	psr_state_t state_d;

	logic [EW-1:0] lo;
	logic [EW-1:0] hi;
	logic [EW-1:0] lo_next;
	logic bad_range;

	logic [EW-1:0] n_q;
	logic [EW-1:0] hi_q;
	logic [DW-1:0] d_q;
	logic [SW-1:0] sq_q;
	logic [SUM_W-1:0] sum_q;
	logic [COUNT_W-1:0] count_q;
	logic invalid_q;
	logic sq_over;
	logic last_n;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SUM_W-1:0] prime_sum_q;
	logic [COUNT_W-1:0] prime_count_q;
	logic slot_free;

	logic load_item;
	logic add_prime;
	logic advance_n;
	logic next_div;
	logic load_out;
	rem_ctl_t rem_ctl;
	rem_stat_t rem_stat;

	// inputs are masked to the value width
	assign lo = req.range_start[EW-1:0];
	assign hi = req.range_end[EW-1:0];
	assign lo_next = lo + 1'b1;
	assign bad_range = (lo == '0) || (lo >= hi);

	assign sq_over = sq_q > SW'(n_q);
	assign last_n = (n_q + 1'b1) == hi_q;
	assign slot_free = !out_valid_q || rsp.ready;

	psr_rem_unit #(
		.NW(EW),
		.DW(DW)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(rem_ctl),
		.dividend(n_q),
		.divisor(d_q),
		.stat(rem_stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (bad_range || lo_next == hi) ? ST_DONE : ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_COMPARE;
			ST_COMPARE: state_d = sq_over ? ST_NEXT : ST_DIVIDE;
			ST_DIVIDE: begin
				if (rem_stat.done) begin
					state_d = rem_stat.zero ? ST_NEXT : ST_SQUARE;
				end
			end
			ST_NEXT: state_d = last_n ? ST_DONE : ST_SQUARE;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		load_item = 1'b0;
		add_prime = 1'b0;
		advance_n = 1'b0;
		next_div = 1'b0;
		load_out = 1'b0;
		rem_ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				load_item = req.valid;
			end
			ST_COMPARE: begin
				// no divisor up to the root: n is prime
				add_prime = sq_over;
				rem_ctl.start = !sq_over;
			end
			ST_DIVIDE: next_div = rem_stat.done && !rem_stat.zero;
			ST_NEXT: advance_n = !last_n;
			ST_DONE: load_out = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			n_q <= lo_next;
			hi_q <= hi;
			d_q <= DW'(FIRST_DIVISOR);
			sum_q <= '0;
			count_q <= '0;
			invalid_q <= bad_range;
		end
		if (state_q == ST_SQUARE) begin
			sq_q <= d_q * d_q;
		end
		if (add_prime) begin
			sum_q <= sum_q + SUM_W'(n_q);
			count_q <= count_q + 1'b1;
		end
		if (next_div) begin
			d_q <= d_q + 1'b1;
		end
		if (advance_n) begin
			n_q <= n_q + 1'b1;
			d_q <= DW'(FIRST_DIVISOR);
		end
		if (load_out) begin
			prime_sum_q <= sum_q;
			prime_count_q <= count_q;
			if (invalid_q) begin
				status_q <= STATUS_INVALID;
			end else if (count_q == '0) begin
				status_q <= STATUS_NONE;
			end else begin
				status_q <= STATUS_FOUND;
			end
		end
	end

	// an invalid range never enters the search, so sum and count stay zero
	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.prime_sum = prime_sum_q;
	assign rsp.prime_count = prime_count_q;

endmodule

FILE: sv/psr_rem_unit.sv
module psr_rem_unit
	import psr_pkg::*;
#(
	parameter int unsigned NW = 16,
	parameter int unsigned DW = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  rem_ctl_t ctl,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output rem_stat_t stat
);

	localparam int unsigned IW = $clog2(NW);

	logic busy_q;
	logic done_q;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] div_q;
	logic [DW-1:0] rem_q;
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic fits;

	// restoring step: one dividend bit per cycle, msb first
	assign trial = {rem_q, num_q[idx_q]};
	assign diff = trial - {1'b0, div_q};
	assign fits = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			idx_q <= IW'(NW - 1);
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			idx_q <= idx_q - 1'b1;
		end
	end

	assign stat.done = done_q;
	assign stat.zero = rem_q == '0;

endmodule

FILE: test/tb_prime_sum_in_open_range_core.sv
module tb_prime_sum_in_open_range_core;
	import psr_pkg::*;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned VALUE_MASK = (1 << VALUE_W) - 1;
	localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;
	localparam int unsigned COUNT_SAT = (1 << COUNT_W) - 1;
	localparam int unsigned RANDOM_RANGES = 80;
	localparam int unsigned STALL_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
	} range_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SUM_W-1:0] prime_sum;
		logic [COUNT_W-1:0] prime_count;
	} prime_tally_t;

	logic clk = 1'b0;
	logic arst_n;

	psr_in_if range_if ();
	psr_out_if sum_if ();

	prime_sum_in_open_range_core #(
		.VALUE_WIDTH(VALUE_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(range_if.sink),
		.rsp(sum_if.source)
	);

	always #6 clk = ~clk;

	range_word_t range_words_q[$];
	prime_tally_t prime_tally_q[$];
	int unsigned mismatch_count = 0;

	function automatic logic is_prime(int unsigned n);
		int unsigned d;
		if (n < FIRST_DIVISOR)
			return 1'b0;
		for (d = FIRST_DIVISOR; d * d <= n; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic prime_tally_t tally_primes(range_word_t w);
		prime_tally_t t;
		int unsigned lo;
		int unsigned hi;
		int unsigned n;
		longint unsigned total;
		int unsigned found;
		lo = w.lo & VALUE_MASK;
		hi = w.hi & VALUE_MASK;
		total = 0;
		found = 0;
		t.status = STATUS_INVALID;
		t.prime_sum = '0;
		t.prime_count = '0;
		if (lo == 0 || lo >= hi)
			return t;
		for (n = lo + 1; n < hi; n++) begin
			if (is_prime(n)) begin
				total += n;
				if (total > SUM_SAT)
					total = SUM_SAT;
				if (found < COUNT_SAT)
					found++;
			end
		end
		t.status = (found == 0) ? STATUS_NONE : STATUS_FOUND;
		t.prime_sum = SUM_W'(total);
		t.prime_count = COUNT_W'(found);
		return t;
	endfunction

	// ranges are kept narrow: one prime near the top takes a division by every divisor up to its root
	function automatic range_word_t random_range();
		range_word_t w;
		int unsigned lo;
		int unsigned hi;
		case ($urandom_range(0, 9))
			0: begin
				lo = 0;
				hi = $urandom_range(0, VALUE_MASK);
			end
			1: begin
				lo = $urandom_range(1, VALUE_MASK);
				hi = $urandom_range(0, lo);
			end
			2, 3, 4, 5, 6: begin
				lo = $urandom_range(1, 1000);
				hi = lo + $urandom_range(1, 40);
			end
			default: begin
				lo = $urandom_range(1, VALUE_MASK - 1);
				hi = lo + $urandom_range(1, 12);
				if (hi > VALUE_MASK)
					hi = VALUE_MASK;
			end
		endcase
		w.lo = FIELD_W'(lo);
		w.hi = FIELD_W'(hi);
		return w;
	endfunction

	// mostly random waits, with runs of back-to-back words now and then
	function automatic int unsigned draw_wait(inout int unsigned calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(4, 12);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	task automatic queue_range(int unsigned lo, int unsigned hi);
		range_word_t w;
		w.lo = FIELD_W'(lo);
		w.hi = FIELD_W'(hi);
		range_words_q.push_back(w);
	endtask

	int unsigned send_wait;
	int unsigned send_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		logic sent;
		range_word_t w;
		if (!arst_n) begin
			range_if.valid <= 1'b0;
			range_if.range_start <= '0;
			range_if.range_end <= '0;
			send_wait = draw_wait(send_calm);
		end else begin
			sent = range_if.valid && range_if.ready;
			if (sent) begin
				w.lo = range_if.range_start;
				w.hi = range_if.range_end;
				prime_tally_q.push_back(tally_primes(w));
				send_wait = draw_wait(send_calm);
			end
			if (!range_if.valid || sent) begin
				if (send_wait == 0 && range_words_q.size() > 0) begin
					w = range_words_q.pop_front();
					range_if.valid <= 1'b1;
					range_if.range_start <= w.lo;
					range_if.range_end <= w.hi;
				end else begin
					range_if.valid <= 1'b0;
					if (send_wait > 0)
						send_wait--;
				end
			end
		end
	end

	int unsigned take_wait;
	int unsigned take_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		prime_tally_t want;
		if (!arst_n) begin
			sum_if.ready <= 1'b0;
			take_wait = draw_wait(take_calm);
		end else begin
			if (sum_if.valid && sum_if.ready) begin
				if (prime_tally_q.size() == 0) begin
					$error("unexpected word: status %0d prime_sum %0d prime_count %0d",
						sum_if.status, sum_if.prime_sum, sum_if.prime_count);
					mismatch_count++;
				end else begin
					want = prime_tally_q.pop_front();
					if (sum_if.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, sum_if.status);
						mismatch_count++;
					end
					if (sum_if.prime_sum !== want.prime_sum) begin
						$error("prime_sum: expected %0d, got %0d",
							want.prime_sum, sum_if.prime_sum);
						mismatch_count++;
					end
					if (sum_if.prime_count !== want.prime_count) begin
						$error("prime_count: expected %0d, got %0d",
							want.prime_count, sum_if.prime_count);
						mismatch_count++;
					end
				end
				take_wait = draw_wait(take_calm);
			end
			if (take_wait > 0) begin
				take_wait--;
				sum_if.ready <= 1'b0;
			end else begin
				sum_if.ready <= 1'b1;
			end
		end
	end

	int unsigned stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((range_if.valid && range_if.ready) || (sum_if.valid && sum_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int unsigned i;
		arst_n = 1'b0;

		// invalid: zero start, start equal to end, start above end
		queue_range(0, 0);
		queue_range(0, VALUE_MASK);
		queue_range(VALUE_MASK, VALUE_MASK);
		queue_range(VALUE_MASK, 0);
		queue_range(5, 5);
		queue_range(6, 5);
		queue_range(1, 0);
		// empty ranges, including ones with no value between the bounds
		queue_range(1, 2);
		queue_range(2, 3);
		queue_range(7, 11);
		queue_range(24, 29);
		queue_range(VALUE_MASK - 1, VALUE_MASK);
		// smallest primes at the low edge
		queue_range(1, 3);
		queue_range(1, 4);
		queue_range(1, 10);
		queue_range(2, 4);
		queue_range(1, 200);
		// largest 16-bit prime is 65521
		queue_range(65520, VALUE_MASK);
		queue_range(32760, 32780);
		queue_range(21845, 21850);
		queue_range(43690, 43700);

		for (i = 0; i < RANDOM_RANGES; i++)
			range_words_q.push_back(random_range());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (range_words_q.size() != 0 || range_if.valid || prime_tally_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
